### sv/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Overlapping implication, checked on every rising edge outside reset.
`define ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Non-overlapping implication: the consequent is checked from the clock edge after the antecedent.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/wcts_pkg.sv
`timescale 1ns / 1ps

package wcts_pkg;

  // Default log2 of the wear cells per texture unit
  localparam int WEAR_CELL_BITS_DEF = 6;

  localparam int FX_UNIT       = 65536;
  localparam int FLUTE_COUNT   = 22;
  localparam int SHADE_MAX     = 15;
  localparam int CARD_RAMP_IDX = 64;
  localparam int TAPE_RAMP_IDX = 80;

  // Tape modes
  localparam logic [1:0] TAPE_OFF    = 2'd0;
  localparam logic [1:0] TAPE_CENTRE = 2'd1;
  localparam logic [1:0] TAPE_BOTTOM = 2'd2;

  // Register indexes
  localparam logic [1:0] REG_HARD_THR    = 2'd0;
  localparam logic [1:0] REG_SOFT_THR    = 2'd1;
  localparam logic [1:0] REG_FLUTE_WIDTH = 2'd2;
  localparam logic [1:0] REG_STRIP_HALF  = 2'd3;

  // Register reset values
  localparam logic [15:0] HARD_THR_RST    = 16'd1310;
  localparam logic [15:0] SOFT_THR_RST    = 16'd3932;
  localparam logic [15:0] FLUTE_WIDTH_RST = 16'd10485;
  localparam logic [15:0] STRIP_HALF_RST  = 16'd5570;

  // One row of the cell-row table: vertical shade term and edge distance
  typedef struct packed {
    logic signed [2:0] vterm;
    logic [15:0]       dv;
  } row_entry_t;

  // Distance of a cell centre to the nearer border of the unit square.
  // A centre is never zero, so 1.0 - c fits 16 bits.
  function automatic logic [15:0] edge_dist(input logic [15:0] c);
    logic [16:0] r;
    r = 17'(FX_UNIT) - {1'b0, c};
    if ({1'b0, c} < r) return c;
    else return r[15:0];
  endfunction

endpackage

### sv/worn_cardboard_texel_shader.sv
`timescale 1ns / 1ps

// Cardboard texel shader: one pixel may start every clock while busy is low,
// and once start is taken its palette index comes out on done through the
// stage 1 and output registers. The per-row part of the wear pattern (flute
// darkening, vertical gradient, distance to the top or bottom border) sits
// in a row table of 2^WEAR_CELL_BITS entries with one read port; the column
// part and the tape tests are computed on the fly. After reset, and after
// every write of flute_width, the row table is rebuilt one row per cycle:
// busy stays high through the rebuild and no pixel is taken meanwhile.
// Configuration writes are always taken (cfg_ready is tied high). The
// result is shown for one cycle only and the receiver cannot stall it.

`include "assert_macros.svh"

module worn_cardboard_texel_shader #(
  parameter int WEAR_CELL_BITS = wcts_pkg::WEAR_CELL_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] tex_u,
  input  logic [31:0] tex_v,
  input  logic [3:0]  light_level,
  input  logic [1:0]  tape_kind,
  output logic        done,
  output logic [6:0]  palette_index,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int SH = 16 - WEAR_CELL_BITS;
  localparam logic [15:0] CENTRE = 16'(1 << (SH - 1));
  localparam int ENTRY_W = $bits(wcts_pkg::row_entry_t);

  logic [15:0] hard_thr;
  logic [15:0] soft_thr;
  logic [15:0] flute_width;
  logic [15:0] strip_half;

  logic                      cfg_wr;
  logic                      accept;
  logic                      fill_we;
  logic [WEAR_CELL_BITS-1:0] fill_addr;
  wcts_pkg::row_entry_t      fill_data;
  logic [ENTRY_W-1:0]        rd_raw;
  wcts_pkg::row_entry_t      rd_entry;

  // Stage 0 signals
  logic [15:0]        cu;
  logic signed [32:0] du_signed;
  logic [32:0]        du_mag;
  logic signed [33:0] band_lim;
  logic               tape_hit;

  // Stage 1 registers
  logic        s1_valid;
  logic        s1_tape;
  logic [3:0]  s1_lvl;
  logic [15:0] s1_du;

  // Stage 1 signals
  logic [15:0]       e_min;
  logic signed [2:0] eterm;
  logic signed [5:0] sum;
  logic [3:0]        shade;
  logic [6:0]        pal_next;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;
  assign accept    = start && !busy;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      hard_thr    <= wcts_pkg::HARD_THR_RST;
      soft_thr    <= wcts_pkg::SOFT_THR_RST;
      flute_width <= wcts_pkg::FLUTE_WIDTH_RST;
      strip_half  <= wcts_pkg::STRIP_HALF_RST;
    end else if (cfg_wr) begin
      unique case (cfg_index)
        wcts_pkg::REG_HARD_THR:    hard_thr    <= cfg_data;
        wcts_pkg::REG_SOFT_THR:    soft_thr    <= cfg_data;
        wcts_pkg::REG_FLUTE_WIDTH: flute_width <= cfg_data;
        wcts_pkg::REG_STRIP_HALF:  strip_half  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Row table build sequencer
  wcts_row_fill #(
    .WEAR_CELL_BITS(WEAR_CELL_BITS)
  ) u_fill (
    .clk         (clk),
    .rst         (rst),
    .restart     (cfg_wr && (cfg_index == wcts_pkg::REG_FLUTE_WIDTH)),
    .flute_width (flute_width),
    .busy        (busy),
    .we          (fill_we),
    .waddr       (fill_addr),
    .wdata       (fill_data)
  );

  // Row table, read at the v cell index of the incoming beat
  wcts_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (1 << WEAR_CELL_BITS)
  ) u_rows (
    .clk   (clk),
    .we    (fill_we),
    .waddr (fill_addr),
    .wdata (fill_data),
    .raddr (tex_v[15 -: WEAR_CELL_BITS]),
    .rdata (rd_raw)
  );

  assign rd_entry = rd_raw;

  // Stage 0: column edge distance and tape tests
  always_comb begin
    cu        = (16'(tex_u[15 -: WEAR_CELL_BITS]) << SH) | CENTRE;
    du_signed = $signed({tex_u[31], tex_u}) - 33'sd32768;
    du_mag    = du_signed[32] ? 33'(-du_signed) : 33'(du_signed);
    band_lim  = 34'sd65536 - $signed({17'b0, strip_half, 1'b0});
    case (tape_kind)
      wcts_pkg::TAPE_CENTRE: tape_hit = du_mag < {17'b0, strip_half};
      wcts_pkg::TAPE_BOTTOM: tape_hit = $signed({{2{tex_v[31]}}, tex_v}) > band_lim;
      default:               tape_hit = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    s1_tape <= tape_hit;
    s1_lvl  <= light_level;
    s1_du   <= wcts_pkg::edge_dist(cu);
  end

  // Stage 1: combine with the row entry, clamp and map to the palette
  always_comb begin
    e_min = (s1_du < rd_entry.dv) ? s1_du : rd_entry.dv;
    if (e_min < hard_thr) eterm = -3'sd3;
    else if (e_min < soft_thr) eterm = -3'sd2;
    else eterm = 3'sd0;
    sum = $signed({2'b00, s1_lvl}) + 6'(eterm) + 6'(rd_entry.vterm);
    if (sum < 6'sd0) shade = 4'd0;
    else if (sum > 6'(wcts_pkg::SHADE_MAX)) shade = 4'(wcts_pkg::SHADE_MAX);
    else shade = sum[3:0];
    if (s1_tape) pal_next = 7'(wcts_pkg::TAPE_RAMP_IDX) + {4'b0, s1_lvl[3:1]};
    else pal_next = 7'(wcts_pkg::CARD_RAMP_IDX) + {3'b0, shade};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    palette_index <= pal_next;
  end

  // Checks
  `ASSERT_IMPL(a_result_two_later, clk, rst, $past(accept, 2), done, "accepted beat lost")
  `ASSERT_IMPL(a_index_range, clk, rst, done, palette_index - 7'd64 < 7'd24, "index out of range")
  `ASSERT_NEXT(a_tape_ramp, clk, rst, s1_valid && s1_tape, palette_index >= 7'd80, "tape ramp")

endmodule

### sv/wcts_ram.sv
`timescale 1ns / 1ps

module wcts_ram #(
  parameter int WIDTH = 19,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### sv/wcts_row_fill.sv
`timescale 1ns / 1ps

module wcts_row_fill #(
  parameter int WEAR_CELL_BITS = wcts_pkg::WEAR_CELL_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      restart,
  input  logic [15:0]               flute_width,
  output logic                      busy,
  output logic                      we,
  output logic [WEAR_CELL_BITS-1:0] waddr,
  output wcts_pkg::row_entry_t      wdata
);

  localparam int SH = 16 - WEAR_CELL_BITS;
  localparam logic [15:0] CENTRE = 16'(1 << (SH - 1));

  logic                      active;
  logic [WEAR_CELL_BITS-1:0] row;
  logic [15:0]               cv;
  logic [20:0]               flute_prod;
  logic signed [2:0]         grad;
  logic signed [2:0]         flute;

  // Sweep every row once after reset and after each flute width write
  always_ff @(posedge clk) begin
    if (rst || restart) begin
      active <= 1'b1;
      row    <= '0;
    end else if (active) begin
      if (row == {WEAR_CELL_BITS{1'b1}}) begin
        active <= 1'b0;
      end else begin
        row <= row + 1'b1;
      end
    end
  end

  // Row entry from the cell centre of this row
  always_comb begin
    cv         = (16'(row) << SH) | CENTRE;
    flute_prod = 21'(cv) * 21'(wcts_pkg::FLUTE_COUNT);
    flute      = (flute_prod[15:0] < flute_width) ? -3'sd1 : 3'sd0;
    grad       = $signed({1'b0, cv[15:14]}) - 3'sd2;
    wdata.vterm = flute + grad;
    wdata.dv    = wcts_pkg::edge_dist(cv);
  end

  assign busy  = active;
  assign we    = active;
  assign waddr = row;

endmodule
